/* src/rffp_pkg.sv */
// Shared types and constants for the ring FIFO frame packer.
// No dependencies; imported by every module of the block but rffp_ram.
`default_nettype none

package rffp_pkg;

	localparam int RING_DEPTH_DEF        = 65536;
	localparam int FRAME_PAYLOAD_MAX_DEF = 1024;
	localparam int QUEUE_DEPTH           = 2;
	localparam int CMP_W                 = 17;

	localparam logic [7:0] SYNC1_BYTE       = 8'hAA;
	localparam logic [7:0] SYNC2_BYTE       = 8'h55;
	localparam logic [7:0] FRAME_TYPE_RESET = 8'h01;
	localparam logic [7:0] BYTE_MASK        = 8'hFF;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_PULL  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} rffp_op_t;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_SYNC2   = 6'b000010,
		PH_TYPE    = 6'b000100,
		PH_LEN_LO  = 6'b001000,
		PH_LEN_HI  = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} rffp_phase_t;

	// result fields as delivered on the output channel
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       frame_start;
		logic       frame_end;
		logic       push_accepted;
	} rffp_result_t;

	// front to back: result with the byte still to be taken from the ring when from_ram
	typedef struct packed {
		logic         from_ram;
		rffp_result_t res;
	} rffp_desc_t;

endpackage

`default_nettype wire

/* src/rffp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rffp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/rffp_queue.sv */
// Two-entry result queue between the stage register and the output channel.
// Depends on rffp_pkg.
`default_nettype none

module rffp_queue
	import rffp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire rffp_result_t push_data,
	output logic              full,
	output logic              head_valid,
	output rffp_result_t      head_data,
	input  wire logic         pop
);

	rffp_result_t entry_q [QUEUE_DEPTH];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign full       = (count_q == 2'(QUEUE_DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* src/rffp_back.sv */
// Back end: stage register that meets the ring read data, then the result queue.
// Depends on rffp_pkg and rffp_queue.
`default_nettype none

module rffp_back
	import rffp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         desc_push,
	input  wire rffp_desc_t   desc,
	output logic              can_take,
	input  wire logic [7:0]   ram_rdata,
	output logic              result_valid,
	output rffp_result_t      result,
	input  wire logic         result_ready
);

	logic         valid_s1;
	rffp_desc_t   desc_s1;
	logic         q_full;
	logic         advance;
	rffp_result_t resolved;

	assign advance  = valid_s1 && !q_full;
	assign can_take = !valid_s1 || !q_full;

	// ring data arrives in the cycle after the read was issued, i.e. while the item sits here;
	// the RAM output holds while the stage stalls since no new read is issued then
	always_comb begin
		resolved = desc_s1.res;
		if (desc_s1.from_ram) begin
			resolved.out_byte = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (desc_push) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_push) begin
			desc_s1 <= desc;
		end
	end

	rffp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (resolved),
		.full      (q_full),
		.head_valid(result_valid),
		.head_data (result),
		.pop       (result_ready)
	);

endmodule

`default_nettype wire

/* src/rffp_front.sv */
// Front end: accepts items, keeps ring pointers, fill count and framing state,
// issues ring writes and reads. Depends on rffp_pkg.
`default_nettype none

module rffp_front
	import rffp_pkg::*;
#(
	parameter int RING_DEPTH        = RING_DEPTH_DEF,
	parameter int FRAME_PAYLOAD_MAX = FRAME_PAYLOAD_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [7:0]                    cfg_write_data,
	input  wire logic                          accept,
	input  wire logic [1:0]                    operation,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          block_first,
	input  wire logic [15:0]                   block_length,
	output rffp_desc_t                         desc,
	output logic                               ram_we,
	output logic [$clog2(RING_DEPTH)-1:0]      ram_waddr,
	output logic [7:0]                         ram_wdata,
	output logic                               ram_re,
	output logic [$clog2(RING_DEPTH)-1:0]      ram_raddr
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int LEN_W = $clog2(FRAME_PAYLOAD_MAX + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

	logic [PTR_W-1:0] wp_q, rp_q, count_q;
	logic [PTR_W-1:0] wp_nx, rp_nx, count_nx;
	rffp_phase_t      phase_q, phase_nx;
	logic [LEN_W-1:0] chunk_q, chunk_nx;
	logic [LEN_W-1:0] left_q, left_nx;
	logic             rej_q, rej_nx;
	logic [7:0]       frame_type_q;

	logic             ring_full;
	logic             blen_over;
	logic [CMP_W-1:0] chunk_sel;
	logic [CMP_W-1:0] keep;
	logic [CMP_W-1:0] wp_sum;
	logic [15:0]      chunk16;
	logic [PTR_W-1:0] rp_inc;
	logic             store;
	logic             read_ring;

	assign ring_full = (count_q == LAST_SLOT);
	// block fits when length <= free slots, i.e. length + fill <= depth - 1
	assign blen_over = (CMP_W'(block_length) + CMP_W'(count_q)) > CMP_W'(RING_DEPTH - 1);
	assign chunk_sel = (CMP_W'(count_q) > CMP_W'(FRAME_PAYLOAD_MAX))
		? CMP_W'(FRAME_PAYLOAD_MAX) : CMP_W'(count_q);
	assign keep      = (CMP_W'(left_q) < CMP_W'(count_q)) ? CMP_W'(left_q) : CMP_W'(count_q);
	assign wp_sum    = CMP_W'(rp_q) + keep;
	assign chunk16   = 16'(chunk_q);
	assign rp_inc    = (rp_q == LAST_SLOT) ? '0 : rp_q + PTR_W'(1);

	always_comb begin
		wp_nx     = wp_q;
		rp_nx     = rp_q;
		count_nx  = count_q;
		phase_nx  = phase_q;
		chunk_nx  = chunk_q;
		left_nx   = left_q;
		rej_nx    = rej_q;
		store     = 1'b0;
		read_ring = 1'b0;
		desc      = '0;

		unique case (rffp_op_t'(operation))
			OP_PUSH: begin
				if (block_first) begin
					rej_nx = blen_over;
				end
				if (!rej_nx && !ring_full) begin
					store                  = 1'b1;
					wp_nx                  = (wp_q == LAST_SLOT) ? '0 : wp_q + PTR_W'(1);
					count_nx               = count_q + PTR_W'(1);
					desc.res.push_accepted = 1'b1;
				end
			end
			OP_PULL: begin
				unique case (phase_q)
					PH_IDLE: begin
						if (count_q != '0) begin
							chunk_nx             = chunk_sel[LEN_W-1:0];
							left_nx              = chunk_sel[LEN_W-1:0];
							desc.res.out_valid   = 1'b1;
							desc.res.out_byte    = SYNC1_BYTE;
							desc.res.frame_start = 1'b1;
							phase_nx             = PH_SYNC2;
						end
					end
					PH_SYNC2: begin
						desc.res.out_valid = 1'b1;
						desc.res.out_byte  = SYNC2_BYTE;
						phase_nx           = PH_TYPE;
					end
					PH_TYPE: begin
						desc.res.out_valid = 1'b1;
						desc.res.out_byte  = frame_type_q;
						phase_nx           = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						desc.res.out_valid = 1'b1;
						desc.res.out_byte  = chunk16[7:0] & BYTE_MASK;
						phase_nx           = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						desc.res.out_valid = 1'b1;
						desc.res.out_byte  = chunk16[15:8] & BYTE_MASK;
						phase_nx           = (left_q != '0) ? PH_PAYLOAD : PH_IDLE;
					end
					PH_PAYLOAD: begin
						if (left_q != '0 && count_q != '0) begin
							read_ring          = 1'b1;
							desc.from_ram      = 1'b1;
							desc.res.out_valid = 1'b1;
							rp_nx              = rp_inc;
							count_nx           = count_q - PTR_W'(1);
							left_nx            = left_q - LEN_W'(1);
							if (left_q == LEN_W'(1)) begin
								desc.res.frame_end = 1'b1;
								phase_nx           = PH_IDLE;
							end
						end else begin
							// frame has no data left to send: close it silently
							left_nx  = '0;
							phase_nx = PH_IDLE;
						end
					end
					default: begin
						phase_nx = PH_IDLE;
					end
				endcase
			end
			OP_FLUSH: begin
				if (phase_q == PH_IDLE) begin
					rp_nx    = wp_q;
					count_nx = '0;
				end else begin
					// keep only what the open frame still owes
					wp_nx    = (wp_sum >= CMP_W'(RING_DEPTH))
						? PTR_W'(wp_sum - CMP_W'(RING_DEPTH)) : PTR_W'(wp_sum);
					count_nx = PTR_W'(keep);
				end
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign ram_we    = accept && store;
	assign ram_waddr = wp_q;
	assign ram_wdata = data_byte;
	assign ram_re    = accept && read_ring;
	assign ram_raddr = rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
			phase_q <= PH_IDLE;
			chunk_q <= '0;
			left_q  <= '0;
			rej_q   <= 1'b0;
		end else if (accept) begin
			wp_q    <= wp_nx;
			rp_q    <= rp_nx;
			count_q <= count_nx;
			phase_q <= phase_nx;
			chunk_q <= chunk_nx;
			left_q  <= left_nx;
			rej_q   <= rej_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_type_q <= FRAME_TYPE_RESET;
		end else if (cfg_write_en) begin
			frame_type_q <= cfg_write_data;
		end
	end

endmodule

`default_nettype wire

/* src/ring_fifo_frame_packer_unit.sv */
// Top level of the ring FIFO frame packer: front end, ring RAM and back end.
// Depends on rffp_pkg, rffp_front, rffp_ram and rffp_back.
`default_nettype none

// Byte FIFO of RING_DEPTH slots (one always kept empty) drained as frames
// AA 55 type len_lo len_hi payload. Every accepted item (push, pull, flush or
// the unused code) gives exactly one result item. One item is accepted per
// clock cycle while item_ready is high. At the accepting edge the front end
// updates pointers and framing state and the ring write or read is done; the
// item then sits in the stage register, where the ring's registered read data
// joins the result, and moves on into a two-entry queue that feeds the
// output, so item_ready falls only when that queue and the stage are both
// held by a stalled output. The ring is one RAM with a write port and a read
// port; it needs no clearing after reset, since only written bytes are read.
module ring_fifo_frame_packer_unit
	import rffp_pkg::*;
#(
	parameter int RING_DEPTH        = RING_DEPTH_DEF,
	parameter int FRAME_PAYLOAD_MAX = FRAME_PAYLOAD_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [7:0]  cfg_write_data,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	input  wire logic        block_first,
	input  wire logic [15:0] block_length,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             frame_start,
	output logic             frame_end,
	output logic             push_accepted
);

	localparam int PTR_W = $clog2(RING_DEPTH);

	logic             accept;
	rffp_desc_t       desc;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic             ram_re;
	logic [PTR_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;
	rffp_result_t     result;

	assign accept = item_valid && item_ready;

	rffp_front #(
		.RING_DEPTH       (RING_DEPTH),
		.FRAME_PAYLOAD_MAX(FRAME_PAYLOAD_MAX)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.accept        (accept),
		.operation     (operation),
		.data_byte     (data_byte),
		.block_first   (block_first),
		.block_length  (block_length),
		.desc          (desc),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr)
	);

	rffp_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rffp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc_push   (accept),
		.desc        (desc),
		.can_take    (item_ready),
		.ram_rdata   (ram_rdata),
		.result_valid(result_valid),
		.result      (result),
		.result_ready(result_ready)
	);

	assign out_valid     = result.out_valid;
	assign out_byte      = result.out_byte;
	assign frame_start   = result.frame_start;
	assign frame_end     = result.frame_end;
	assign push_accepted = result.push_accepted;

endmodule

`default_nettype wire
